// ===== sv/fse_pkg.sv =====
// Package for the three-stack engine: command and status codes, request and response payloads,
// sequencer states. No dependencies.
package fse_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH = 4'd0, CMD_POP = 4'd1, CMD_PUSH2 = 4'd2, CMD_POP2 = 4'd3,
    CMD_DROP = 4'd4, CMD_PICK = 4'd5, CMD_ROLL = 4'd6, CMD_DEPTH = 4'd7,
    CMD_RPUSH = 4'd8, CMD_RPOP = 4'd9, CMD_TOR = 4'd10, CMD_FROMR = 4'd11,
    CMD_TOCS = 4'd12, CMD_FROMCS = 4'd13, CMD_CLRDATA = 4'd14, CMD_CLRRET = 4'd15
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DOVF = 3'd1, ST_DUNF = 3'd2, ST_ROVF = 3'd3,
    ST_RUNF = 3'd4, ST_COVF = 3'd5, ST_CUNF = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] value;
    logic [31:0] value_high;
  } cmd_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic [31:0] result_high;
    status_e     status;
    logic [6:0]  data_depth;
    logic        return_empty;
  } cmd_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_PICK, S_ROLL_RD, S_ROLL_WR, S_ROLL_END, S_TOR2, S_OUT
  } state_e;

endpackage

// ===== sv/fse_if.sv =====
// Valid/ready channel carrying a payload struct type.
// No dependencies.
interface fse_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/fse_ram.sv =====
// Synchronous single-port-write, single-read memory with a registered read port.
// No dependencies.
module fse_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/forth_three_stack_engine_top.sv =====
// Three-stack engine top level: command sequencer and two stack memories.
// Depends on fse_pkg, fse_if and fse_ram.
//
// Usage: commands arrive on in_if (cmd, value, value_high) and each gives exactly one
// result on out_if (result, result_high, status, data_depth, return_empty).
// Both channels are valid/ready; a request moves when both are high.
// One command is worked on at a time; the sequencer returns to idle after a result is
// taken and accepts the next command there. States passed, all ending in S_OUT:
//   S_RD1 for push, drop, depth, rpush, clears and faults found from the counts;
//   S_RD1, S_EXEC for push2; S_RD1, S_RD2 for pop, rpop, tocs, fromcs and a bad pick
//   or roll count; S_RD1, S_RD2, S_EXEC for pop2 and fromr; S_RD1, S_RD2, S_PICK for
//   pick; S_RD1, S_RD2, S_TOR2, S_ROLL_END for tor; roll goes S_RD1, S_RD2, S_ROLL_RD
//   (one read ahead), S_ROLL_WR (one shifted entry written per cycle), S_ROLL_END.
// Data cells sit in one memory; return and control cells share a second one.
// The result sits in an output register; in_if.ready is low until it is taken,
// so a stalled receiver simply holds the block.
// Reset clears the three counts and the sequencer; memory contents stay unknown
// but are never read before being written, since reads only reach below count.
// Faulting commands change nothing.
module forth_three_stack_engine_top #(
  parameter int DATA_DEPTH    = 64,
  parameter int RETURN_DEPTH  = 64,
  parameter int CONTROL_DEPTH = 32,
  parameter int CELL_BITS     = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  fse_if.sink   in_if,
  fse_if.source out_if
);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int CAW = $clog2(CONTROL_DEPTH);
  localparam int DCW = $clog2(DATA_DEPTH + 1);
  localparam int RCW = $clog2(RETURN_DEPTH + 1);
  localparam int CCW = $clog2(CONTROL_DEPTH + 1);
  localparam int RCD  = RETURN_DEPTH + CONTROL_DEPTH;
  localparam int RCAW = $clog2(RCD);

  // Payload layout of interface structs: in {cmd, value, value_high},
  // out {result, result_high, status, data_depth, return_empty}.

  fse_pkg::state_e state_q, state_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic [CCW-1:0] ccnt_q, ccnt_d;
  fse_pkg::cmd_e  cmd_q, cmd_d;
  logic [CELL_BITS-1:0] v_q, v_d, vh_q, vh_d, t0_q, t0_d, t1_q, t1_d;
  logic [DCW-1:0] pos_q, pos_d;
  logic [31:0] res_q, res_d, resh_q, resh_d;
  fse_pkg::status_e st_q, st_d;

  // Memory ports
  logic            d_we, r_we, c_we;
  logic [DAW-1:0]  d_wa, d_ra;
  logic [RAW-1:0]  r_wa, r_ra;
  logic [CAW-1:0]  c_wa, c_ra;
  logic [CELL_BITS-1:0] d_wd, r_wd, c_wd, d_rd, r_rd, c_rd;

  // Shared return/control memory: return entries first, control entries above.
  logic             rc_we;
  logic [RCAW-1:0]  rc_wa, rc_ra;
  logic [CELL_BITS-1:0] rc_wd, rc_rd;

  fse_ram #(.Depth(DATA_DEPTH), .Width(CELL_BITS)) u_dram (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd), .raddr_i(d_ra), .rdata_o(d_rd));
  fse_ram #(.Depth(RCD), .Width(CELL_BITS)) u_rcram (
    .clk_i, .we_i(rc_we), .waddr_i(rc_wa), .wdata_i(rc_wd), .raddr_i(rc_ra),
    .rdata_o(rc_rd));

  // No command touches both return and control cells in one cycle.
  always_comb begin
    rc_we = r_we | c_we;
    rc_wa = c_we ? RCAW'(RETURN_DEPTH) + RCAW'(c_wa) : RCAW'(r_wa);
    rc_wd = c_we ? c_wd : r_wd;
    rc_ra = (cmd_q == fse_pkg::CMD_FROMCS) ? RCAW'(RETURN_DEPTH) + RCAW'(c_ra)
                                           : RCAW'(r_ra);
  end

  assign r_rd = rc_rd;
  assign c_rd = rc_rd;

  function automatic logic [31:0] sext(input logic [CELL_BITS-1:0] c);
    sext = 32'($signed(c));
  endfunction

  // Pick/roll count from the top cell: unsigned view when non-negative.
  logic [DCW-1:0] rest;
  logic           cnt_bad;
  logic [DCW-1:0] n_cut;
  always_comb begin
    rest  = dcnt_q - DCW'(1);
    cnt_bad = d_rd[CELL_BITS-1];
    if (CELL_BITS > DCW) begin
      if ((d_rd >> DCW) != '0) cnt_bad = 1'b1;
    end
    n_cut = DCW'(d_rd);
    if (n_cut >= rest) cnt_bad = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fse_pkg::S_IDLE;
      dcnt_q  <= '0;
      rcnt_q  <= '0;
      ccnt_q  <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      rcnt_q  <= rcnt_d;
      ccnt_q  <= ccnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; v_q <= v_d; vh_q <= vh_d; t0_q <= t0_d; t1_q <= t1_d;
    pos_q <= pos_d; res_q <= res_d; resh_q <= resh_d; st_q <= st_d;
  end

  always_comb begin
    state_d = state_q;
    dcnt_d = dcnt_q; rcnt_d = rcnt_q; ccnt_d = ccnt_q;
    cmd_d = cmd_q; v_d = v_q; vh_d = vh_q; t0_d = t0_q; t1_d = t1_q;
    pos_d = pos_q; res_d = res_q; resh_d = resh_q; st_d = st_q;
    d_we = 1'b0; r_we = 1'b0; c_we = 1'b0;
    d_wa = DAW'(dcnt_q); d_wd = v_q; d_ra = DAW'(dcnt_q - DCW'(1));
    r_wa = RAW'(rcnt_q); r_wd = v_q; r_ra = RAW'(rcnt_q - RCW'(1));
    c_wa = CAW'(ccnt_q); c_wd = d_rd; c_ra = CAW'(ccnt_q - CCW'(1));
    in_if.ready = 1'b0;
    out_if.valid = 1'b0;

    case (state_q)
      fse_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cmd_d = fse_pkg::cmd_e'(in_if.data.cmd);
          v_d  = CELL_BITS'(in_if.data.value);
          vh_d = CELL_BITS'(in_if.data.value_high);
          res_d = '0; resh_d = '0; st_d = fse_pkg::ST_OK;
          state_d = fse_pkg::S_RD1;
        end
      end

      // Bound checks, first read issued (address defaults: tops).
      fse_pkg::S_RD1: begin
        state_d = fse_pkg::S_OUT;
        case (cmd_q)
          fse_pkg::CMD_PUSH: begin
            if (dcnt_q >= DCW'(DATA_DEPTH)) st_d = fse_pkg::ST_DOVF;
            else begin d_we = 1'b1; dcnt_d = dcnt_q + DCW'(1); end
          end
          fse_pkg::CMD_PUSH2: begin
            if ({1'b0, dcnt_q} + (DCW+1)'(2) > (DCW+1)'(DATA_DEPTH)) st_d = fse_pkg::ST_DOVF;
            else begin d_we = 1'b1; state_d = fse_pkg::S_EXEC; end
          end
          fse_pkg::CMD_DEPTH: begin
            if (dcnt_q >= DCW'(DATA_DEPTH)) st_d = fse_pkg::ST_DOVF;
            else begin
              d_we = 1'b1; d_wd = CELL_BITS'(dcnt_q); dcnt_d = dcnt_q + DCW'(1);
            end
          end
          fse_pkg::CMD_POP, fse_pkg::CMD_PICK, fse_pkg::CMD_ROLL: begin
            if (dcnt_q == '0) st_d = fse_pkg::ST_DUNF;
            else state_d = fse_pkg::S_RD2;
          end
          fse_pkg::CMD_POP2: begin
            if (dcnt_q < DCW'(2)) st_d = fse_pkg::ST_DUNF;
            else state_d = fse_pkg::S_RD2;
          end
          fse_pkg::CMD_DROP: begin
            if (dcnt_q == '0) st_d = fse_pkg::ST_DUNF;
            else dcnt_d = dcnt_q - DCW'(1);
          end
          fse_pkg::CMD_RPUSH: begin
            if (rcnt_q >= RCW'(RETURN_DEPTH)) st_d = fse_pkg::ST_ROVF;
            else begin r_we = 1'b1; rcnt_d = rcnt_q + RCW'(1); end
          end
          fse_pkg::CMD_RPOP: begin
            if (rcnt_q == '0) st_d = fse_pkg::ST_RUNF;
            else state_d = fse_pkg::S_RD2;
          end
          fse_pkg::CMD_TOR: begin
            if (rcnt_q == '0) st_d = fse_pkg::ST_RUNF;
            else if (dcnt_q == '0) st_d = fse_pkg::ST_DUNF;
            else if (rcnt_q >= RCW'(RETURN_DEPTH)) st_d = fse_pkg::ST_ROVF;
            else state_d = fse_pkg::S_RD2;
          end
          fse_pkg::CMD_FROMR: begin
            if (rcnt_q < RCW'(2)) st_d = fse_pkg::ST_RUNF;
            else if (dcnt_q >= DCW'(DATA_DEPTH)) st_d = fse_pkg::ST_DOVF;
            else begin r_ra = RAW'(rcnt_q - RCW'(2)); state_d = fse_pkg::S_RD2; end
          end
          fse_pkg::CMD_TOCS: begin
            if (ccnt_q >= CCW'(CONTROL_DEPTH)) st_d = fse_pkg::ST_COVF;
            else if (dcnt_q == '0) st_d = fse_pkg::ST_DUNF;
            else state_d = fse_pkg::S_RD2;
          end
          fse_pkg::CMD_FROMCS: begin
            if (ccnt_q == '0) st_d = fse_pkg::ST_CUNF;
            else if (dcnt_q >= DCW'(DATA_DEPTH)) st_d = fse_pkg::ST_DOVF;
            else state_d = fse_pkg::S_RD2;
          end
          fse_pkg::CMD_CLRDATA: dcnt_d = '0;
          fse_pkg::CMD_CLRRET: begin rcnt_d = '0; ccnt_d = '0; end
          default: ;
        endcase
      end

      // First read data available.
      fse_pkg::S_RD2: begin
        state_d = fse_pkg::S_OUT;
        case (cmd_q)
          fse_pkg::CMD_POP: begin res_d = sext(d_rd); dcnt_d = dcnt_q - DCW'(1); end
          fse_pkg::CMD_POP2: begin
            resh_d = sext(d_rd);
            d_ra = DAW'(dcnt_q - DCW'(2));
            state_d = fse_pkg::S_EXEC;
          end
          fse_pkg::CMD_RPOP: begin res_d = sext(r_rd); rcnt_d = rcnt_q - RCW'(1); end
          fse_pkg::CMD_TOCS: begin
            c_we = 1'b1; ccnt_d = ccnt_q + CCW'(1); dcnt_d = dcnt_q - DCW'(1);
          end
          fse_pkg::CMD_FROMCS: begin
            d_we = 1'b1; d_wd = c_rd; dcnt_d = dcnt_q + DCW'(1); ccnt_d = ccnt_q - CCW'(1);
          end
          fse_pkg::CMD_FROMR: begin
            // push second return entry; then move top down one
            d_we = 1'b1; d_wd = r_rd; dcnt_d = dcnt_q + DCW'(1);
            state_d = fse_pkg::S_EXEC;
          end
          fse_pkg::CMD_TOR: begin
            t0_d = d_rd; t1_d = r_rd;
            state_d = fse_pkg::S_TOR2;
          end
          default: begin // pick, roll: d_rd is the count
            if (cnt_bad) st_d = fse_pkg::ST_DUNF;
            else begin
              pos_d = rest - DCW'(1) - n_cut;
              d_ra = DAW'(rest - DCW'(1) - n_cut);
              state_d = (cmd_q == fse_pkg::CMD_PICK) ? fse_pkg::S_PICK : fse_pkg::S_ROLL_RD;
            end
          end
        endcase
      end

      fse_pkg::S_EXEC: begin
        state_d = fse_pkg::S_OUT;
        case (cmd_q)
          fse_pkg::CMD_PUSH2: begin
            d_we = 1'b1; d_wa = DAW'(dcnt_q + DCW'(1)); d_wd = vh_q;
            dcnt_d = dcnt_q + DCW'(2);
          end
          fse_pkg::CMD_POP2: begin res_d = sext(d_rd); dcnt_d = dcnt_q - DCW'(2); end
          default: begin // fromr: top return entry moves down
            r_we = 1'b1; r_wa = RAW'(rcnt_q - RCW'(2)); r_wd = r_rd;
            rcnt_d = rcnt_q - RCW'(1);
          end
        endcase
      end

      fse_pkg::S_TOR2: begin
        r_we = 1'b1; r_wa = RAW'(rcnt_q - RCW'(1)); r_wd = t0_q;
        dcnt_d = dcnt_q - DCW'(1);
        state_d = fse_pkg::S_ROLL_END;
      end

      fse_pkg::S_PICK: begin
        d_we = 1'b1; d_wa = DAW'(rest); d_wd = d_rd;
        state_d = fse_pkg::S_OUT;
      end

      // Roll: d_rd holds the moved entry; shift pos+1..rest-1 down by one.
      fse_pkg::S_ROLL_RD: begin
        t0_d = d_rd;
        d_ra = DAW'(pos_q + DCW'(1));
        state_d = (pos_q + DCW'(1) < rest) ? fse_pkg::S_ROLL_WR : fse_pkg::S_ROLL_END;
      end
      fse_pkg::S_ROLL_WR: begin
        d_we = 1'b1; d_wa = DAW'(pos_q); d_wd = d_rd;
        pos_d = pos_q + DCW'(1);
        d_ra = DAW'(pos_q + DCW'(2));
        state_d = (pos_q + DCW'(2) < rest) ? fse_pkg::S_ROLL_WR : fse_pkg::S_ROLL_END;
      end
      fse_pkg::S_ROLL_END: begin
        if (cmd_q == fse_pkg::CMD_TOR) begin
          r_we = 1'b1; r_wd = t1_q; rcnt_d = rcnt_q + RCW'(1);
        end else begin
          d_we = 1'b1; d_wa = DAW'(rest - DCW'(1)); d_wd = t0_q;
          dcnt_d = dcnt_q - DCW'(1);
        end
        state_d = fse_pkg::S_OUT;
      end

      fse_pkg::S_OUT: begin
        out_if.valid = 1'b1;
        if (out_if.ready) state_d = fse_pkg::S_IDLE;
      end

      default: state_d = fse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_if.data.result       = res_q;
    out_if.data.result_high  = resh_q;
    out_if.data.status       = st_q;
    out_if.data.data_depth   = 7'(dcnt_q);
    out_if.data.return_empty = (rcnt_q == '0);
  end

  // Counts never exceed their bounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= DCW'(DATA_DEPTH) && rcnt_q <= RCW'(RETURN_DEPTH))
    else $error("stack count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ccnt_q <= CCW'(CONTROL_DEPTH)) else $error("control count out of range");
  // While a faulting result waits unaccepted, the data count stays unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fse_pkg::S_OUT && st_q != fse_pkg::ST_OK && !out_if.ready)
      |=> $stable(dcnt_q)) else $error("count moved after fault");
  // No new command is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("overlap of commands");
endmodule

// ===== tb/forth_three_stack_engine_top_test.sv =====
// Testbench for the three-stack engine: directed and random command streams,
// each result checked against an in-bench predictor of the three stacks.
// Depends on fse_pkg, fse_if and forth_three_stack_engine_top.
module forth_three_stack_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DSZ = 64;
  localparam int RSZ = 64;
  localparam int CSZ = 32;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 1520;

  logic clk_i;
  logic rst_ni;

  fse_if #(.T(fse_pkg::cmd_req_t)) in_if ();
  fse_if #(.T(fse_pkg::cmd_rsp_t)) out_if ();

  forth_three_stack_engine_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Predictor state: a private copy of the three stacks.
  logic [31:0] data_cells[DSZ];
  logic [31:0] ret_cells[RSZ];
  logic [31:0] ctl_cells[CSZ];
  int          data_cnt;
  int          ret_cnt;
  int          ctl_cnt;

  fse_pkg::cmd_rsp_t pending_rsp[$];
  int          error_cnt;
  int          cycle_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog; a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
    error_cnt++;
  endtask

  // Apply one command to the predicted stacks; faults leave them untouched.
  task automatic predict_stacks(input fse_pkg::cmd_req_t rq,
                                output fse_pkg::cmd_rsp_t rs);
    logic [31:0] n;
    logic [31:0] moved;
    int          rest;
    int          pos;
    rs = '0;
    rs.status = fse_pkg::ST_OK;
    case (rq.cmd)
      fse_pkg::CMD_PUSH: begin
        if (data_cnt >= DSZ) rs.status = fse_pkg::ST_DOVF;
        else begin
          data_cells[data_cnt] = rq.value;
          data_cnt++;
        end
      end
      fse_pkg::CMD_POP: begin
        if (data_cnt == 0) rs.status = fse_pkg::ST_DUNF;
        else begin
          data_cnt--;
          rs.result = data_cells[data_cnt];
        end
      end
      fse_pkg::CMD_PUSH2: begin
        if (data_cnt + 2 > DSZ) rs.status = fse_pkg::ST_DOVF;
        else begin
          data_cells[data_cnt] = rq.value;
          data_cells[data_cnt+1] = rq.value_high;
          data_cnt += 2;
        end
      end
      fse_pkg::CMD_POP2: begin
        if (data_cnt < 2) rs.status = fse_pkg::ST_DUNF;
        else begin
          rs.result_high = data_cells[data_cnt-1];
          rs.result = data_cells[data_cnt-2];
          data_cnt -= 2;
        end
      end
      fse_pkg::CMD_DROP: begin
        if (data_cnt == 0) rs.status = fse_pkg::ST_DUNF;
        else data_cnt--;
      end
      fse_pkg::CMD_PICK, fse_pkg::CMD_ROLL: begin
        if (data_cnt == 0) rs.status = fse_pkg::ST_DUNF;
        else begin
          n = data_cells[data_cnt-1];
          rest = data_cnt - 1;
          // negative count or one reaching past the bottom is underflow
          if (n[31] || n >= rest) rs.status = fse_pkg::ST_DUNF;
          else begin
            pos = rest - 1 - int'(n);
            moved = data_cells[pos];
            if (rq.cmd == fse_pkg::CMD_PICK) data_cells[rest] = moved;
            else begin
              for (int i = pos; i + 1 < rest; i++) data_cells[i] = data_cells[i+1];
              data_cells[rest-1] = moved;
              data_cnt = rest;
            end
          end
        end
      end
      fse_pkg::CMD_DEPTH: begin
        if (data_cnt >= DSZ) rs.status = fse_pkg::ST_DOVF;
        else begin
          data_cells[data_cnt] = data_cnt;
          data_cnt++;
        end
      end
      fse_pkg::CMD_RPUSH: begin
        if (ret_cnt >= RSZ) rs.status = fse_pkg::ST_ROVF;
        else begin
          ret_cells[ret_cnt] = rq.value;
          ret_cnt++;
        end
      end
      fse_pkg::CMD_RPOP: begin
        if (ret_cnt == 0) rs.status = fse_pkg::ST_RUNF;
        else begin
          ret_cnt--;
          rs.result = ret_cells[ret_cnt];
        end
      end
      fse_pkg::CMD_TOR: begin
        if (ret_cnt == 0) rs.status = fse_pkg::ST_RUNF;
        else if (data_cnt == 0) rs.status = fse_pkg::ST_DUNF;
        else if (ret_cnt >= RSZ) rs.status = fse_pkg::ST_ROVF;
        else begin
          data_cnt--;
          ret_cells[ret_cnt] = ret_cells[ret_cnt-1];
          ret_cells[ret_cnt-1] = data_cells[data_cnt];
          ret_cnt++;
        end
      end
      fse_pkg::CMD_FROMR: begin
        if (ret_cnt < 2) rs.status = fse_pkg::ST_RUNF;
        else if (data_cnt >= DSZ) rs.status = fse_pkg::ST_DOVF;
        else begin
          data_cells[data_cnt] = ret_cells[ret_cnt-2];
          data_cnt++;
          ret_cells[ret_cnt-2] = ret_cells[ret_cnt-1];
          ret_cnt--;
        end
      end
      fse_pkg::CMD_TOCS: begin
        if (ctl_cnt >= CSZ) rs.status = fse_pkg::ST_COVF;
        else if (data_cnt == 0) rs.status = fse_pkg::ST_DUNF;
        else begin
          data_cnt--;
          ctl_cells[ctl_cnt] = data_cells[data_cnt];
          ctl_cnt++;
        end
      end
      fse_pkg::CMD_FROMCS: begin
        if (ctl_cnt == 0) rs.status = fse_pkg::ST_CUNF;
        else if (data_cnt >= DSZ) rs.status = fse_pkg::ST_DOVF;
        else begin
          ctl_cnt--;
          data_cells[data_cnt] = ctl_cells[ctl_cnt];
          data_cnt++;
        end
      end
      fse_pkg::CMD_CLRDATA: data_cnt = 0;
      default: begin
        ret_cnt = 0;
        ctl_cnt = 0;
      end
    endcase
    rs.data_depth = data_cnt[6:0];
    rs.return_empty = (ret_cnt == 0);
  endtask

  // Send one request; valid is only lowered when an idle gap is taken.
  task automatic send_cmd(input fse_pkg::cmd_e c, input logic [31:0] v,
                          input logic [31:0] vh);
    fse_pkg::cmd_req_t rq;
    fse_pkg::cmd_rsp_t rs;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    rq.cmd = c;
    rq.value = v;
    rq.value_high = vh;
    in_if.valid <= 1'b1;
    in_if.data <= rq;
    do @(posedge clk_i); while (!in_if.ready);
    predict_stacks(rq, rs);
    pending_rsp.push_back(rs);
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin
    fse_pkg::cmd_rsp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", out_if.data.result, 32'h0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_if.data.result !== want.result)
          report_mismatch("result", out_if.data.result, want.result);
        if (out_if.data.result_high !== want.result_high)
          report_mismatch("result_high", out_if.data.result_high, want.result_high);
        if (out_if.data.status !== want.status)
          report_mismatch("status", 32'(out_if.data.status), 32'(want.status));
        if (out_if.data.data_depth !== want.data_depth)
          report_mismatch("data_depth", 32'(out_if.data.data_depth), 32'(want.data_depth));
        if (out_if.data.return_empty !== want.return_empty)
          report_mismatch("return_empty", 32'(out_if.data.return_empty),
                          32'(want.return_empty));
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_cell();
    case ($urandom_range(0, 7))
      0: rand_cell = 32'h8000_0000;
      1: rand_cell = 32'h7fff_ffff;
      2: rand_cell = 32'hffff_ffff;
      3: rand_cell = 32'h0;
      default: rand_cell = $urandom();
    endcase
  endfunction

  // Pushes the count, then the pick or roll that consumes it.
  task automatic send_indexed(input fse_pkg::cmd_e c);
    logic [31:0] n;
    if (data_cnt > 0 && $urandom_range(0, 9) < 8)
      n = (data_cnt > 12 && $urandom_range(0, 3) != 0) ? $urandom_range(0, 10)
                                                       : $urandom_range(0, data_cnt - 1);
    else n = rand_cell();
    send_cmd(fse_pkg::CMD_PUSH, n, rand_cell());
    send_cmd(c, rand_cell(), rand_cell());
  endtask

  task automatic test_directed();
    send_cmd(fse_pkg::CMD_POP, 0, 0);               // data underflow on empty stack
    send_cmd(fse_pkg::CMD_POP2, 0, 0);
    send_cmd(fse_pkg::CMD_DROP, 0, 0);
    send_cmd(fse_pkg::CMD_PICK, 0, 0);
    send_cmd(fse_pkg::CMD_RPOP, 0, 0);              // return underflow
    send_cmd(fse_pkg::CMD_TOR, 0, 0);
    send_cmd(fse_pkg::CMD_FROMR, 0, 0);
    send_cmd(fse_pkg::CMD_FROMCS, 0, 0);            // control underflow
    send_cmd(fse_pkg::CMD_PUSH, 32'h8000_0000, 32'hffff_ffff);
    send_cmd(fse_pkg::CMD_PUSH2, 32'h7fff_ffff, 32'h8000_0000);
    send_cmd(fse_pkg::CMD_DEPTH, 0, 0);
    send_cmd(fse_pkg::CMD_PUSH, 32'hffff_ffff, 0);  // negative count
    send_cmd(fse_pkg::CMD_PICK, 0, 0);
    send_cmd(fse_pkg::CMD_PUSH, 32'd2, 0);
    send_cmd(fse_pkg::CMD_PICK, 0, 0);
    send_cmd(fse_pkg::CMD_PUSH, 32'd3, 0);
    send_cmd(fse_pkg::CMD_ROLL, 0, 0);
    send_cmd(fse_pkg::CMD_POP2, 0, 0);
    send_cmd(fse_pkg::CMD_RPUSH, 32'h1234_5678, 0);
    send_cmd(fse_pkg::CMD_TOR, 0, 0);
    send_cmd(fse_pkg::CMD_FROMR, 0, 0);
    send_cmd(fse_pkg::CMD_TOCS, 0, 0);
    send_cmd(fse_pkg::CMD_FROMCS, 0, 0);
    send_cmd(fse_pkg::CMD_CLRDATA, 0, 0);
    send_cmd(fse_pkg::CMD_CLRRET, 0, 0);
  endtask

  // Bias swings between filling and draining so both bounds are hit.
  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    int  r;
    bit  fill;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    fill = 1'b1;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 59) == 0) fill = !fill;
      r = $urandom_range(0, 99);
      if (r < 8) send_indexed(fse_pkg::CMD_PICK);
      else if (r < 14) send_indexed(fse_pkg::CMD_ROLL);
      else if (r < 96) begin
        case ($urandom_range(0, fill ? 15 : 19))
          0, 16: send_cmd(fse_pkg::CMD_POP, rand_cell(), rand_cell());
          1:     send_cmd(fse_pkg::CMD_PUSH2, rand_cell(), rand_cell());
          2, 17: send_cmd(fse_pkg::CMD_POP2, rand_cell(), rand_cell());
          3, 18: send_cmd(fse_pkg::CMD_DROP, rand_cell(), rand_cell());
          4:     send_cmd(fse_pkg::CMD_DEPTH, rand_cell(), rand_cell());
          5:     send_cmd(fse_pkg::CMD_RPUSH, rand_cell(), rand_cell());
          6, 19: send_cmd(fse_pkg::CMD_RPOP, rand_cell(), rand_cell());
          7:     send_cmd(fse_pkg::CMD_TOR, rand_cell(), rand_cell());
          8:     send_cmd(fse_pkg::CMD_FROMR, rand_cell(), rand_cell());
          9:     send_cmd(fse_pkg::CMD_TOCS, rand_cell(), rand_cell());
          10:    send_cmd(fse_pkg::CMD_FROMCS, rand_cell(), rand_cell());
          default: send_cmd(fse_pkg::CMD_PUSH, rand_cell(), rand_cell());
        endcase
      end else send_cmd($urandom_range(0, 1) ? fse_pkg::CMD_CLRDATA : fse_pkg::CMD_CLRRET,
                        rand_cell(), rand_cell());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    error_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    data_cnt = 0;
    ret_cnt = 0;
    ctl_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(RANDOM_ITEMS / 4, 0, 0);
    test_random(RANDOM_ITEMS / 4, 49, 0);
    test_random(RANDOM_ITEMS / 4, 0, 49);
    test_random(RANDOM_ITEMS / 4, 25, 25);
    in_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
